### rtl/ute_pkg.sv
`default_nettype none
package ute_pkg;

  localparam int unsigned CpW = 21;
  localparam int unsigned CharW = 7;

  localparam logic [CharW-1:0] CharBslash = 7'h5C;
  localparam logic [CharW-1:0] CharU      = 7'h75;

  localparam logic [2:0] Lead2Pat = 3'b110;
  localparam logic [3:0] Lead3Pat = 4'b1110;
  localparam logic [4:0] Lead4Pat = 5'b11110;

  typedef struct packed {
    logic           esc;
    logic [CpW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/ute_front.sv
`default_nettype none
module ute_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    in_byte_i,
  output ute_pkg::cmd_t      cmd_o,
  output logic               cmd_push_o
);

  logic [ute_pkg::CpW-1:0] cp_q, cp_d;
  logic [1:0]              left_q, left_d;
  logic [ute_pkg::CpW-1:0] cp_shift;

  assign cp_shift = {cp_q[ute_pkg::CpW-7:0], in_byte_i[5:0]};

  always_comb begin
    cp_d       = cp_q;
    left_d     = left_q;
    cmd_push_o = 1'b0;
    cmd_o.esc  = 1'b1;
    cmd_o.value = '0;
    if (accept_i) begin
      priority if (left_q != 2'd0) begin
        cp_d   = cp_shift;
        left_d = left_q - 2'd1;
        if (left_q == 2'd1) begin
          cmd_push_o  = 1'b1;
          cmd_o.value = cp_shift;
        end
      end else if (!in_byte_i[7]) begin
        cmd_push_o  = 1'b1;
        cmd_o.esc   = 1'b0;
        cmd_o.value = {{(ute_pkg::CpW-7){1'b0}}, in_byte_i[6:0]};
      end else if (in_byte_i[7:5] == ute_pkg::Lead2Pat) begin
        cp_d   = {{(ute_pkg::CpW-5){1'b0}}, in_byte_i[4:0]};
        left_d = 2'd1;
      end else if (in_byte_i[7:4] == ute_pkg::Lead3Pat) begin
        cp_d   = {{(ute_pkg::CpW-4){1'b0}}, in_byte_i[3:0]};
        left_d = 2'd2;
      end else if (in_byte_i[7:3] == ute_pkg::Lead4Pat) begin
        cp_d   = {{(ute_pkg::CpW-3){1'b0}}, in_byte_i[2:0]};
        left_d = 2'd3;
      end else begin
        cmd_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q   <= '0;
      left_q <= 2'd0;
    end else begin
      cp_q   <= cp_d;
      left_q <= left_d;
    end
  end

endmodule
`default_nettype wire

### rtl/ute_cmd_fifo.sv
`default_nettype none
module ute_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ute_pkg::cmd_t wdata_i,
  input  wire logic          pop_i,
  output ute_pkg::cmd_t      rdata_o,
  output ute_pkg::fifo_stat_t stat_o
);

  ute_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

### rtl/ute_back.sv
`default_nettype none
module ute_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ute_pkg::cmd_t  cmd_i,
  input  wire logic           cmd_empty_i,
  output logic                cmd_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [6:0]          out_char_o,
  output logic                run_last_o
);

  ute_pkg::cmd_t cur_q;
  logic          cur_valid_q, cur_valid_d;
  logic [2:0]    idx_q, idx_d;
  logic          out_valid_q, out_valid_d;
  logic [6:0]    char_q;
  logic          last_q;

  logic          out_free, advance, last_char, load;
  logic [2:0]    ndig, nchar, pos;
  logic [23:0]   padded;
  logic [3:0]    nib;
  logic [6:0]    chr;

  always_comb begin
    if (cur_q.value[20:16] == 5'd0) begin
      ndig = 3'd4;
    end else if (!cur_q.value[20]) begin
      ndig = 3'd5;
    end else begin
      ndig = 3'd6;
    end
  end

  assign nchar     = cur_q.esc ? ndig + 3'd2 : 3'd1;
  assign last_char = (idx_q == nchar - 3'd1);
  assign pos       = ndig + 3'd1 - idx_q;
  assign padded    = {3'b000, cur_q.value};

  always_comb begin
    case (pos)
      3'd0:    nib = padded[3:0];
      3'd1:    nib = padded[7:4];
      3'd2:    nib = padded[11:8];
      3'd3:    nib = padded[15:12];
      3'd4:    nib = padded[19:16];
      3'd5:    nib = padded[23:20];
      default: nib = 4'd0;
    endcase
  end

  always_comb begin
    priority if (!cur_q.esc) begin
      chr = cur_q.value[6:0];
    end else if (idx_q == 3'd0) begin
      chr = ute_pkg::CharBslash;
    end else if (idx_q == 3'd1) begin
      chr = ute_pkg::CharU;
    end else begin
      chr = ute_pkg::hex_char(nib);
    end
  end

  assign out_free  = !out_valid_q || pop_i;
  assign advance   = cur_valid_q && out_free;
  assign load      = !cmd_empty_i && (!cur_valid_q || (advance && last_char));
  assign cmd_pop_o = load;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (load) begin
      cur_valid_d = 1'b1;
      idx_d       = 3'd0;
    end else if (advance) begin
      if (last_char) begin
        cur_valid_d = 1'b0;
      end
      idx_d = idx_q + 3'd1;
    end
    out_valid_d = advance ? 1'b1 : (out_valid_q && !pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
    if (advance) begin
      char_q <= chr;
      last_q <= last_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_char_o = char_q;
  assign run_last_o = last_q;

endmodule
`default_nettype wire

### rtl/utf8_to_unicode_escape.sv
`default_nettype none
// UTF-8 bytes go in through push/full and ASCII characters come out through
// empty/pop, one character per transfer; run_last_o marks the final character
// caused by an input byte. The front end decodes one byte per cycle and hands
// finished characters to a two-entry command queue; the back end writes one
// output character per cycle into a single output register while that is
// free or being popped, so ASCII text flows at one byte per cycle. A byte that
// completes a sequence or is a bad lead byte yields an escape (backslash, 'u',
// four to six uppercase hex digits), and input backs up once the queue fills.
// Continuation and lead bytes that finish nothing give no output.
module utf8_to_unicode_escape (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [6:0]      out_char_o,
  output logic            run_last_o
);

  ute_pkg::cmd_t       cmd_w, cmd_r;
  ute_pkg::fifo_stat_t cmd_stat;
  logic                cmd_push, cmd_pop, accept;

  assign full   = cmd_stat.full;
  assign accept = push && !full;

  ute_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .cmd_o      (cmd_w),
    .cmd_push_o (cmd_push)
  );

  ute_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_w),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_r),
    .stat_o  (cmd_stat)
  );

  ute_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_r),
    .cmd_empty_i (cmd_stat.empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o)
  );

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_stat.full)
    else $error("command written into full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_stat.empty)
    else $error("command read from empty queue");

  a_escape_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !run_last_o) |->
      ((out_char_o == ute_pkg::CharBslash) || (out_char_o == ute_pkg::CharU) ||
       ((out_char_o >= 7'h30) && (out_char_o <= 7'h39)) ||
       ((out_char_o >= 7'h41) && (out_char_o <= 7'h46))))
    else $error("unexpected character inside escape");

endmodule
`default_nettype wire

### verif/utf8_to_unicode_escape_tb.sv
`timescale 1ns / 1ps

module utf8_to_unicode_escape_tb;

  localparam logic [ute_pkg::CharW-1:0] DigitZero = 7'h30;
  localparam logic [ute_pkg::CharW-1:0] LetterA   = 7'h41;

  localparam int unsigned TotalBytes  = 200;
  localparam int unsigned IdlePercent = 18;

  localparam logic [7:0] SampleText [26] = '{
    8'h00, 8'h7F, 8'h80, 8'hF8, 8'hFF,
    8'hC2, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hED, 8'hA0, 8'h80,
    8'hF0, 8'h9F, 8'h98, 8'h80,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hC3, 8'h41,
    8'hE0, 8'hF0, 8'hFF
  };

  typedef struct packed {
    logic [ute_pkg::CharW-1:0] ch;
    logic                      last;
  } esc_char_t;

  class escape_scoreboard;
    esc_char_t                 expected_chars[$];
    logic [ute_pkg::CpW-1:0]   code_point;
    logic [1:0]                bytes_left;
    int                        errors;

    function new();
      code_point = '0;
      bytes_left = '0;
      errors     = 0;
    endfunction

    function void push_escape(logic [ute_pkg::CpW-1:0] value);
      int         ndig;
      logic [3:0] nib;
      esc_char_t  c;
      ndig = (value < 21'h10000) ? 4 : (value < 21'h100000) ? 5 : 6;
      expected_chars.push_back('{ute_pkg::CharBslash, 1'b0});
      expected_chars.push_back('{ute_pkg::CharU, 1'b0});
      for (int k = ndig - 1; k >= 0; k--) begin
        nib    = 4'(value >> (4 * k));
        c.ch   = (nib < 4'd10) ? DigitZero + 7'(nib) : LetterA + 7'(nib) - 7'd10;
        c.last = (k == 0);
        expected_chars.push_back(c);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      if (bytes_left != 0) begin
        code_point = {code_point[ute_pkg::CpW-7:0], b[5:0]};
        bytes_left = bytes_left - 2'd1;
        if (bytes_left == 0) begin
          push_escape(code_point);
        end
      end else if (!b[7]) begin
        expected_chars.push_back('{b[6:0], 1'b1});
      end else if (b[7:5] == ute_pkg::Lead2Pat) begin
        code_point = ute_pkg::CpW'(b[4:0]);
        bytes_left = 2'd1;
      end else if (b[7:4] == ute_pkg::Lead3Pat) begin
        code_point = ute_pkg::CpW'(b[3:0]);
        bytes_left = 2'd2;
      end else if (b[7:3] == ute_pkg::Lead4Pat) begin
        code_point = ute_pkg::CpW'(b[2:0]);
        bytes_left = 2'd3;
      end else begin
        push_escape('0);
      end
    endfunction

    function void check_char(logic [ute_pkg::CharW-1:0] ch, logic last);
      esc_char_t exp_c;
      if (expected_chars.size() == 0) begin
        $error("out_char: no character expected, got %h", ch);
        errors++;
        return;
      end
      exp_c = expected_chars.pop_front();
      if (ch !== exp_c.ch) begin
        $error("out_char mismatch: expected %h, got %h", exp_c.ch, ch);
        errors++;
      end
      if (last !== exp_c.last) begin
        $error("run_last mismatch: expected %b, got %b", exp_c.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      push;
  logic                      full;
  logic [7:0]                in_byte_i;
  logic                      empty;
  logic                      pop;
  logic [ute_pkg::CharW-1:0] out_char_o;
  logic                      run_last_o;

  escape_scoreboard sb;
  logic             gaps_on;
  int unsigned      sent_bytes;

  utf8_to_unicode_escape dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .empty      (empty),
    .pop        (pop),
    .out_char_o (out_char_o),
    .run_last_o (run_last_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // stall the output side at random while gaps are enabled
  always @(posedge clk_i) begin
    pop <= rst_ni && !(gaps_on && $urandom_range(99) < IdlePercent);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_char(out_char_o, run_last_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < IdlePercent) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    sb.note_byte(b);
    sent_bytes++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic send_random_unit();
    int unsigned pick;
    int unsigned ncont;
    logic [7:0]  lead;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_byte(8'($urandom_range(127)));
    end else if (pick < 85) begin
      ncont = $urandom_range(1, 3);
      case (ncont)
        1: begin
          lead = {ute_pkg::Lead2Pat, 5'($urandom_range(31))};
        end
        2: begin
          lead = {ute_pkg::Lead3Pat, 4'($urandom_range(15))};
        end
        default: begin
          lead = {ute_pkg::Lead4Pat, 3'($urandom_range(7))};
        end
      endcase
      send_byte(lead);
      repeat (ncont) send_byte({2'b10, 6'($urandom_range(63))});
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic pressure_done;
    sb            = new();
    rst_ni        = 1'b0;
    push          = 1'b0;
    pop           = 1'b0;
    in_byte_i     = 8'h00;
    gaps_on       = 1'b1;
    sent_bytes    = 0;
    pressure_done = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (SampleText[i]) send_byte(SampleText[i]);

    while (sent_bytes < TotalBytes) begin
      // hold a long stretch with no gaps on either side
      gaps_on = !(sent_bytes >= 90 && sent_bytes < 140);
      if (!pressure_done && sent_bytes >= 60) begin
        wait_drained();
        pressure_done = 1'b1;
      end
      send_random_unit();
    end

    gaps_on = 1'b1;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
